// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared forms for the concurrent checks of the header parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk, off while in reset
`define BTLV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define BTLV_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/btlv_pkg.sv -----
// ----------------------------------------------------------------------------
// btlv_pkg
// types and codes shared by the ber tag/length header parser
// ----------------------------------------------------------------------------
package btlv_pkg;

	// parse phase, one-hot
	typedef enum logic [3:0] {
		PH_IDENT    = 4'b0001,
		PH_TAGEXT   = 4'b0010,
		PH_LENFIRST = 4'b0100,
		PH_LENLONG  = 4'b1000
	} phase_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO_ID  = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_TAG_OVF  = 3'd3,
		ST_LEN_OVF  = 3'd4
	} status_t;

	localparam logic [4:0] HIGH_TAG_MARK = 5'h1f;
	localparam logic [7:0] HDR_LEN_MAX   = 8'd255;

	// parser state carried from byte to byte
	typedef struct packed {
		phase_t      phase;
		logic [1:0]  tag_class;
		logic        constructed;
		logic [28:0] tag_accum;
		logic [31:0] length_accum;
		logic [6:0]  len_left;
		logic [7:0]  byte_count;
		logic        tag_ovf;
		logic        len_ovf;
	} state_t;

	// parser state after reset
	localparam state_t STATE_RESET = '{
		phase:        PH_IDENT,
		tag_class:    2'd0,
		constructed:  1'b0,
		tag_accum:    29'd0,
		length_accum: 32'd0,
		len_left:     7'd0,
		byte_count:   8'd0,
		tag_ovf:      1'b0,
		len_ovf:      1'b0
	};

	// one decoded header
	typedef struct packed {
		status_t     status;
		logic [1:0]  tag_class;
		logic        constructed;
		logic [28:0] tag_number;
		logic [31:0] content_length;
		logic [7:0]  header_length;
	} result_t;

endpackage

// ----- sv/btlv_intf.sv -----
// ----------------------------------------------------------------------------
// btlv interfaces
// valid/ready channels for the byte stream and the decoded headers
// ----------------------------------------------------------------------------

// byte stream channel
interface btlv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// decoded header channel
interface btlv_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  tag_class;
	logic        constructed;
	logic [28:0] tag_number;
	logic [31:0] content_length;
	logic [7:0]  header_length;

	modport source (
		output valid, output status, output tag_class, output constructed,
		output tag_number, output content_length, output header_length,
		input ready
	);
	modport sink (
		input valid, input status, input tag_class, input constructed,
		input tag_number, input content_length, input header_length,
		output ready
	);
endinterface

// ----- sv/btlv_step.sv -----
// ----------------------------------------------------------------------------
// btlv_step
// decode of one stream byte against the current parser state
// ----------------------------------------------------------------------------
module btlv_step import btlv_pkg::*; (
	input  state_t     cur,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output state_t     nxt,
	output logic       emit,
	output result_t    res
);

	status_t st;

	// next state and result status
	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		st   = ST_OK;
		if (cur.phase != PH_IDENT && cur.byte_count != HDR_LEN_MAX) begin
			nxt.byte_count = cur.byte_count + 8'd1;
		end
		case (cur.phase)
			PH_IDENT: begin
				nxt.byte_count   = 8'd1;
				nxt.tag_ovf      = 1'b0;
				nxt.len_ovf      = 1'b0;
				nxt.length_accum = '0;
				nxt.len_left     = '0;
				if (data_byte == 8'h00) begin
					// zero identifier, reported at once
					nxt.tag_class   = '0;
					nxt.constructed = 1'b0;
					nxt.tag_accum   = '0;
					nxt.phase       = PH_IDENT;
					emit            = 1'b1;
					st              = ST_ZERO_ID;
				end else begin
					nxt.tag_class   = data_byte[7:6];
					nxt.constructed = data_byte[5];
					if (data_byte[4:0] == HIGH_TAG_MARK) begin
						nxt.tag_accum = '0;
						nxt.phase     = PH_TAGEXT;
					end else begin
						nxt.tag_accum = {24'd0, data_byte[4:0]};
						nxt.phase     = PH_LENFIRST;
					end
					if (last_byte) begin
						emit = 1'b1;
						st   = ST_TRUNC;
					end
				end
			end
			PH_TAGEXT: begin
				// base-128 tag extension
				if (|cur.tag_accum[28:22]) begin
					nxt.tag_ovf = 1'b1;
				end
				nxt.tag_accum = {cur.tag_accum[21:0], data_byte[6:0]};
				if (!data_byte[7]) begin
					nxt.phase = PH_LENFIRST;
				end
				if (last_byte) begin
					emit = 1'b1;
					st   = ST_TRUNC;
				end
			end
			PH_LENFIRST: begin
				if (!data_byte[7]) begin
					// short form length
					nxt.length_accum = {24'd0, data_byte};
					emit             = 1'b1;
					st               = cur.tag_ovf ? ST_TAG_OVF :
						(cur.len_ovf ? ST_LEN_OVF : ST_OK);
				end else begin
					nxt.length_accum = '0;
					nxt.len_left     = data_byte[6:0];
					if (data_byte[6:0] == 7'd0) begin
						// indefinite marker reads as length zero
						emit = 1'b1;
						st   = cur.tag_ovf ? ST_TAG_OVF :
							(cur.len_ovf ? ST_LEN_OVF : ST_OK);
					end else begin
						nxt.phase = PH_LENLONG;
						if (last_byte) begin
							emit = 1'b1;
							st   = ST_TRUNC;
						end
					end
				end
			end
			PH_LENLONG: begin
				// big-endian long form length bytes
				if (|cur.length_accum[31:24]) begin
					nxt.len_ovf = 1'b1;
				end
				nxt.length_accum = {cur.length_accum[23:0], data_byte};
				if (cur.len_left != 7'd0) begin
					nxt.len_left = cur.len_left - 7'd1;
				end
				if (nxt.len_left == 7'd0) begin
					emit = 1'b1;
					st   = cur.tag_ovf ? ST_TAG_OVF :
						(nxt.len_ovf ? ST_LEN_OVF : ST_OK);
				end else if (last_byte) begin
					emit = 1'b1;
					st   = ST_TRUNC;
				end
			end
			default: begin
				nxt.phase = PH_IDENT;
			end
		endcase
		if (emit) begin
			nxt.phase = PH_IDENT;
		end
	end

	// result fields from the updated state
	always_comb begin
		res.status         = st;
		res.tag_class      = nxt.tag_class;
		res.constructed    = nxt.constructed;
		res.tag_number     = nxt.tag_accum;
		res.content_length = nxt.length_accum;
		res.header_length  = nxt.byte_count;
	end

endmodule

// ----- sv/ber_tlv_header_parser.sv -----
// ----------------------------------------------------------------------------
// ber_tlv_header_parser
// streaming decoder of asn.1 ber identifier and length headers
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and reports one result per header: class,
// constructed bit, tag number, content length and header length, or an error
// status for a zero identifier, a truncated header or a tag or length
// overflow. Throughput is one byte per clock, sustained while the result side
// keeps up; a byte lands in the input register, from which the per-byte decode
// updates the parser state and loads the result register that drives the output.
// While a result waits, the byte in the input register waits with it. The rate
// is set by the combinational byte decode, which updates the parser state once
// per byte.
module ber_tlv_header_parser import btlv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	btlv_in_if.sink           byte_stream,
	btlv_out_if.source        header
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_nxt;
	logic       emit;
	result_t    res;
	logic       valid_s2;
	result_t    res_s2;
	logic       step_fire;
	logic       in_fire;

	// handshake
	assign step_fire         = valid_s1 && (!valid_s2 || header.ready);
	assign byte_stream.ready = !valid_s1 || step_fire;
	assign in_fire           = byte_stream.valid && byte_stream.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= byte_stream.data_byte;
			last_s1 <= byte_stream.last_byte;
		end
	end

	// byte decode
	btlv_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (step_fire) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_fire && emit) begin
			valid_s2 <= 1'b1;
		end else if (header.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire && emit) begin
			res_s2 <= res;
		end
	end

	assign header.valid          = valid_s2;
	assign header.status         = res_s2.status;
	assign header.tag_class      = res_s2.tag_class;
	assign header.constructed    = res_s2.constructed;
	assign header.tag_number     = res_s2.tag_number;
	assign header.content_length = res_s2.content_length;
	assign header.header_length  = res_s2.header_length;

endmodule

// ----- sv/btlv_checker.sv -----
// ----------------------------------------------------------------------------
// btlv_checker
// port-level checks on the header parser results, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btlv_checker import btlv_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [28:0] tag_number,
	input logic [31:0] content_length,
	input logic [7:0]  header_length
);

	// a stalled result holds
	`BTLV_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(header_length) && $stable(content_length)), "result dropped or changed while stalled")

	// zero identifier is a one-byte header with empty fields
	`BTLV_ASSERT_IMPLY(a_zero_id, out_valid && status == ST_ZERO_ID, header_length == 8'd1 && tag_number == '0 && content_length == '0, "zero identifier result malformed")

	// a complete header has at least identifier and length bytes
	`BTLV_ASSERT_IMPLY(a_ok_len, out_valid && (status == ST_OK || status == ST_LEN_OVF), header_length >= 8'd2, "complete header too short")

	// tag overflow needs five extension bytes
	`BTLV_ASSERT_IMPLY(a_tag_ovf_len, out_valid && status == ST_TAG_OVF, header_length >= 8'd7, "tag overflow on too short a header")

endmodule

bind ber_tlv_header_parser btlv_checker u_btlv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (header.valid),
	.out_ready      (header.ready),
	.status         (header.status),
	.tag_number     (header.tag_number),
	.content_length (header.content_length),
	.header_length  (header.header_length)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ber tag/length header parser
// ----------------------------------------------------------------------------
// Bytes are queued up front: a short directed set, then random headers. Most
// are well formed with random fields, and the rest are zero identifiers,
// noise and cut-off headers. A clocked driver feeds them with random gaps and
// stalls the result side at random. A header decoder in the bench predicts
// each result as a byte is taken. A clocked monitor checks each result,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import btlv_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int STREAM_BYTES = 1125;
	localparam int IDLE_PCT     = 24;

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain;
	} stream_byte_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	btlv_in_if  byte_if ();
	btlv_out_if hdr_if ();

	ber_tlv_header_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_if),
		.header      (hdr_if)
	);

	// stimulus drive, known from time zero
	logic       drv_valid = 1'b0;
	logic [7:0] drv_data  = 8'h00;
	logic       drv_last  = 1'b0;
	logic       hdr_ready = 1'b0;

	assign byte_if.valid     = drv_valid;
	assign byte_if.data_byte = drv_data;
	assign byte_if.last_byte = drv_last;
	assign hdr_if.ready      = hdr_ready;

	stream_byte_t pending_bytes [$];
	result_t      expected_headers [$];

	int bytes_accepted = 0;
	int headers_seen   = 0;
	int mismatches     = 0;
	int stall_cycles   = 0;
	int status_seen [5];
	bit byte_taken     = 1'b0;
	stream_byte_t next_byte;

	// no gaps on either side over one stretch of the stream
	wire steady = (bytes_accepted >= 300) && (bytes_accepted < 550);

	// decoder state, as after reset
	phase_t      dec_phase   = PH_IDENT;
	logic [1:0]  dec_class   = '0;
	logic        dec_cons    = 1'b0;
	logic [28:0] dec_tag     = '0;
	logic [31:0] dec_len     = '0;
	logic [6:0]  dec_left    = '0;
	logic [7:0]  dec_hdr_len = '0;
	logic        dec_tag_ovf = 1'b0;
	logic        dec_len_ovf = 1'b0;

	always #5 clk = ~clk;

	// status of a header that completes
	function automatic status_t closing_status();
		if (dec_tag_ovf)
			return ST_TAG_OVF;
		if (dec_len_ovf)
			return ST_LEN_OVF;
		return ST_OK;
	endfunction

	// advance the decoder by one byte, queue a result if the header ends
	task automatic decode_byte(input logic [7:0] b, input logic last);
		result_t hdr;
		status_t st;
		bit      done;
		done = 1'b0;
		st   = ST_OK;
		if (dec_phase == PH_IDENT) begin
			dec_hdr_len = 8'd1;
			dec_tag_ovf = 1'b0;
			dec_len_ovf = 1'b0;
			dec_len     = '0;
			dec_left    = '0;
			if (b == 8'h00) begin
				// zero identifier beats truncation
				dec_class = '0;
				dec_cons  = 1'b0;
				dec_tag   = '0;
				st        = ST_ZERO_ID;
				done      = 1'b1;
			end else begin
				dec_class = b[7:6];
				dec_cons  = b[5];
				if (b[4:0] == HIGH_TAG_MARK) begin
					dec_tag   = '0;
					dec_phase = PH_TAGEXT;
				end else begin
					dec_tag   = {24'd0, b[4:0]};
					dec_phase = PH_LENFIRST;
				end
				if (last) begin
					st   = ST_TRUNC;
					done = 1'b1;
				end
			end
		end else begin
			if (dec_hdr_len < HDR_LEN_MAX)
				dec_hdr_len = dec_hdr_len + 8'd1;
			case (dec_phase)
				PH_TAGEXT: begin
					// base-128 tag extension
					if (dec_tag[28:22] != '0)
						dec_tag_ovf = 1'b1;
					dec_tag = {dec_tag[21:0], b[6:0]};
					if (!b[7])
						dec_phase = PH_LENFIRST;
					if (last) begin
						st   = ST_TRUNC;
						done = 1'b1;
					end
				end
				PH_LENFIRST: begin
					if (!b[7]) begin
						dec_len = {24'd0, b};
						st      = closing_status();
						done    = 1'b1;
					end else begin
						dec_len  = '0;
						dec_left = b[6:0];
						if (dec_left == '0) begin
							st   = closing_status();
							done = 1'b1;
						end else begin
							dec_phase = PH_LENLONG;
							if (last) begin
								st   = ST_TRUNC;
								done = 1'b1;
							end
						end
					end
				end
				default: begin
					// long-form length, big-endian
					if (dec_len[31:24] != '0)
						dec_len_ovf = 1'b1;
					dec_len = {dec_len[23:0], b};
					if (dec_left != '0)
						dec_left = dec_left - 7'd1;
					if (dec_left == '0) begin
						st   = closing_status();
						done = 1'b1;
					end else if (last) begin
						st   = ST_TRUNC;
						done = 1'b1;
					end
				end
			endcase
		end
		if (done) begin
			hdr.status         = st;
			hdr.tag_class      = dec_class;
			hdr.constructed    = dec_cons;
			hdr.tag_number     = dec_tag;
			hdr.content_length = dec_len;
			hdr.header_length  = dec_hdr_len;
			expected_headers.insert(expected_headers.size(), hdr);
			dec_phase = PH_IDENT;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic add_byte(input logic [7:0] data, input logic last);
		stream_byte_t sb;
		sb.data  = data;
		sb.last  = last;
		sb.drain = 1'b0;
		pending_bytes.insert(pending_bytes.size(), sb);
	endtask

	// one random header; huge ones saturate the header length
	task automatic gen_header(input bit huge);
		logic [7:0] hdr [$];
		logic [7:0] id;
		logic [7:0] b;
		int kind;
		int n_ext;
		int n_len;
		int cut;
		kind = $urandom_range(99);
		if (!huge && kind < 5) begin
			add_byte(8'h00, 1'($urandom_range(1)));
			return;
		end
		if (!huge && kind < 12) begin
			repeat ($urandom_range(1, 4))
				add_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
			return;
		end
		id = 8'($urandom_range(1, 255));
		if (huge || $urandom_range(99) < 40)
			id[4:0] = HIGH_TAG_MARK;
		else if (id[4:0] == HIGH_TAG_MARK)
			id[4:0] = 5'($urandom_range(30));
		hdr.insert(hdr.size(), id);
		if (id[4:0] == HIGH_TAG_MARK) begin
			n_ext = huge ? 130 :
				($urandom_range(9) == 0 ? $urandom_range(5, 7) : $urandom_range(1, 4));
			for (int k = 0; k < n_ext; k++) begin
				b    = 8'($urandom_range(255));
				b[7] = (k != n_ext - 1);
				hdr.insert(hdr.size(), b);
			end
		end
		kind = $urandom_range(99);
		if (!huge && kind < 45) begin
			hdr.insert(hdr.size(), 8'($urandom_range(127)));
		end else if (!huge && kind < 52) begin
			hdr.insert(hdr.size(), 8'h80);
		end else begin
			n_len = huge ? 127 :
				($urandom_range(9) == 0 ? $urandom_range(5, 8) : $urandom_range(1, 4));
			hdr.insert(hdr.size(), 8'h80 | n_len[7:0]);
			for (int k = 0; k < n_len; k++) begin
				b = 8'($urandom_range(255));
				if ($urandom_range(3) == 0)
					b = 8'h00;
				hdr.insert(hdr.size(), b);
			end
		end
		if (!huge && $urandom_range(99) < 12) begin
			// cut short, last flag on a byte that cannot close the header
			cut = $urandom_range(hdr.size() - 2);
			for (int k = 0; k <= cut; k++)
				add_byte(hdr[k], k == cut);
		end else begin
			foreach (hdr[k])
				add_byte(hdr[k], (k == hdr.size() - 1) && ($urandom_range(4) == 0));
		end
	endtask

	// request side: byte taken into the predictor
	always @(posedge clk) begin
		byte_taken = byte_if.valid && byte_if.ready;
		if (byte_taken) begin
			decode_byte(byte_if.data_byte, byte_if.last_byte);
			bytes_accepted++;
		end
	end

	// driver and result-side stalls, at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!drv_valid || byte_taken) begin
				if (pending_bytes.size() != 0 &&
						(!pending_bytes[0].drain || expected_headers.size() == 0) &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
					next_byte = pending_bytes.pop_front();
					drv_valid <= 1'b1;
					drv_data  <= next_byte.data;
					drv_last  <= next_byte.last;
				end else begin
					drv_valid <= 1'b0;
				end
			end
			hdr_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (hdr_if.valid && hdr_if.ready) begin
			headers_seen++;
			if (hdr_if.status < 5)
				status_seen[hdr_if.status]++;
			if (expected_headers.size() == 0) begin
				$error("result with no header pending: status %0d", hdr_if.status);
				mismatches++;
			end else begin
				want = expected_headers.pop_front();
				check_field("status", 32'(want.status), 32'(hdr_if.status));
				check_field("tag_class", 32'(want.tag_class), 32'(hdr_if.tag_class));
				check_field("constructed", 32'(want.constructed), 32'(hdr_if.constructed));
				check_field("tag_number", 32'(want.tag_number), 32'(hdr_if.tag_number));
				check_field("content_length", want.content_length, hdr_if.content_length);
				check_field("header_length", 32'(want.header_length),
					32'(hdr_if.header_length));
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((byte_if.valid && byte_if.ready) || (hdr_if.valid && hdr_if.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$error("watchdog: no handshake for %0d cycles, %0d headers pending",
					stall_cycles, expected_headers.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int hdr_idx;
		int first;

		// directed: zero identifier with last set
		add_byte(8'h00, 1'b1);
		// short form, universal primitive
		add_byte(8'h02, 1'b0);
		add_byte(8'h05, 1'b0);
		// private constructed high tag, two extension bytes, length 0x80
		add_byte(8'hff, 1'b0);
		add_byte(8'h81, 1'b0);
		add_byte(8'h7f, 1'b0);
		add_byte(8'h80, 1'b0);
		// long form, one length byte at its maximum
		add_byte(8'h30, 1'b0);
		add_byte(8'h81, 1'b0);
		add_byte(8'hff, 1'b0);
		// truncated right after the identifier
		add_byte(8'ha1, 1'b1);
		// tag overflow on the fifth extension byte
		add_byte(8'h1f, 1'b0);
		repeat (4)
			add_byte(8'hff, 1'b0);
		add_byte(8'h7f, 1'b0);
		add_byte(8'h00, 1'b0);
		// length overflow on five long-form bytes
		add_byte(8'h04, 1'b0);
		add_byte(8'h85, 1'b0);
		add_byte(8'h01, 1'b0);
		repeat (4)
			add_byte(8'h00, 1'b0);

		// random headers, a few stream pauses until all results are in
		hdr_idx = 0;
		while (pending_bytes.size() < STREAM_BYTES) begin
			first = pending_bytes.size();
			gen_header(hdr_idx == 60 || hdr_idx == 120);
			if (hdr_idx % 40 == 0)
				pending_bytes[first].drain = 1'b1;
			hdr_idx++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || drv_valid || expected_headers.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("stream of %0d bytes gave %0d headers: %0d ok, %0d zero id, %0d truncated,",
			bytes_accepted, headers_seen, status_seen[0], status_seen[1], status_seen[2]);
		$display("%0d tag overflow, %0d length overflow", status_seen[3], status_seen[4]);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/btlv_pkg.sv
sv/btlv_intf.sv
sv/btlv_step.sv
sv/ber_tlv_header_parser.sv
sv/btlv_checker.sv
dv/tb.sv
